### sv/wall_segment_chain_order_macros.svh
// ----------------------------------------------------------------------------
// wall_segment_chain_order_macros
// assertion macros used by the chain ordering controller
// ----------------------------------------------------------------------------
`ifndef WALL_SEGMENT_CHAIN_ORDER_MACROS_SVH
`define WALL_SEGMENT_CHAIN_ORDER_MACROS_SVH

// property must hold at every clock edge outside reset
`define WSCO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define WSCO_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/wsco_pkg.sv
// ----------------------------------------------------------------------------
// wsco_pkg
// shared constants, controller states, multiply ops and control structs
// ----------------------------------------------------------------------------
package wsco_pkg;

    localparam int WSCO_MAX_SEGMENTS = 32;
    localparam int WSCO_COORD_BITS   = 32;
    localparam int FIELD_W           = 32;
    localparam int SRC_IDX_W         = 5;

    // controller states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SCAN  = 9'b000000010,
        ST_READ  = 9'b000000100,
        ST_LATCH = 9'b000001000,
        ST_MGO   = 9'b000010000,
        ST_MWAIT = 9'b000100000,
        ST_CHECK = 9'b001000000,
        ST_EVAL  = 9'b010000000,
        ST_EMIT  = 9'b100000000
    } state_t;

    // ordering phase
    typedef enum logic [1:0] {
        PH_LINE   = 2'd0,
        PH_ORIENT = 2'd1,
        PH_CHAIN  = 2'd2,
        PH_OUT    = 2'd3
    } phase_t;

    // multiply operations of the shared multiplier
    typedef enum logic [3:0] {
        MOP_L_DX,
        MOP_L_DY,
        MOP_AXBY,
        MOP_AYBX,
        MOP_XX,
        MOP_CBL,
        MOP_BCL,
        MOP_QS_DX,
        MOP_QS_DY,
        MOP_QE_DX,
        MOP_QE_DY
    } mop_t;

    typedef struct packed {
        logic wr_en;
        logic pose_ld;
        logic seg_ld;
        logic mul_go;
        mop_t mop;
        logic best_ld;
        logic chain_mode;
        logic emit_ld;
        logic emit_rev;
        logic emit_last;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic l_zero;
        logic prod_less;
        logic end_nearer;
        logic dist_less;
    } stat_t;

endpackage

### sv/wsco_in_if.sv
// ----------------------------------------------------------------------------
// wsco_in_if
// segment input channel: valid/ready plus one segment word
// ----------------------------------------------------------------------------
interface wsco_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic               last_segment;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;

    modport source (
        output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
        output last_segment, pose_x, pose_y,
        input  ready
    );
    modport sink (
        input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
        input  last_segment, pose_x, pose_y,
        output ready
    );
endinterface

### sv/wsco_out_if.sv
// ----------------------------------------------------------------------------
// wsco_out_if
// ordered segment output channel: valid/ready plus one result word
// ----------------------------------------------------------------------------
interface wsco_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_start_x;
    logic signed [31:0] out_start_y;
    logic signed [31:0] out_end_x;
    logic signed [31:0] out_end_y;
    logic [4:0]         source_index;
    logic               was_reversed;
    logic               last_out;

    modport source (
        output valid, out_start_x, out_start_y, out_end_x, out_end_y,
        output source_index, was_reversed, last_out,
        input  ready
    );
    modport sink (
        input  valid, out_start_x, out_start_y, out_end_x, out_end_y,
        input  source_index, was_reversed, last_out,
        output ready
    );
endinterface

### sv/wsco_ram.sv
// ----------------------------------------------------------------------------
// wsco_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module wsco_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/wsco_mul.sv
// ----------------------------------------------------------------------------
// wsco_mul
// unsigned shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module wsco_mul #(
    parameter int AW = 134,
    parameter int BW = 67,
    localparam int CNTW = $clog2(BW + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [AW+BW-1:0] p
);

    logic [AW+BW-1:0] acc_reg, acc_next;
    logic [AW+BW-1:0] a_reg, a_next;
    logic [BW-1:0]    b_reg, b_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    // next-value logic for one step
    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (go)
        begin
            acc_next  = '0;
            a_next    = (AW+BW)'(a);
            b_next    = b;
            cnt_next  = CNTW'(BW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = a_reg << 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // operand and accumulator registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

### sv/wsco_dp.sv
// ----------------------------------------------------------------------------
// wsco_dp
// datapath: segment store, shared multiplier, distance and cross terms
// ----------------------------------------------------------------------------
module wsco_dp import wsco_pkg::*; #(
    parameter int MAX_SEGMENTS = WSCO_MAX_SEGMENTS,
    parameter int COORD_BITS   = WSCO_COORD_BITS,
    localparam int IW          = $clog2(MAX_SEGMENTS)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output stat_t                     stat,
    input  logic [IW-1:0]             wr_idx,
    input  logic [IW-1:0]             rd_idx,
    input  logic signed [FIELD_W-1:0] seg_start_x,
    input  logic signed [FIELD_W-1:0] seg_start_y,
    input  logic signed [FIELD_W-1:0] seg_end_x,
    input  logic signed [FIELD_W-1:0] seg_end_y,
    input  logic signed [FIELD_W-1:0] pose_x,
    input  logic signed [FIELD_W-1:0] pose_y,
    output logic signed [FIELD_W-1:0] out_start_x,
    output logic signed [FIELD_W-1:0] out_start_y,
    output logic signed [FIELD_W-1:0] out_end_x,
    output logic signed [FIELD_W-1:0] out_end_y,
    output logic [SRC_IDX_W-1:0]      source_index,
    output logic                      was_reversed,
    output logic                      last_out
);

    localparam int CB  = COORD_BITS;
    localparam int DW  = CB + 1;
    localparam int SQW = 2 * DW;
    localparam int LW  = SQW + 1;
    localparam int CW  = 2 * LW;
    localparam int PW  = CW + LW;

    // magnitude of a coordinate difference
    function automatic logic [DW-1:0] absd(logic signed [CB-1:0] a, logic signed [CB-1:0] b);
        logic [DW-1:0] d;
        d = {a[CB-1], a} - {b[CB-1], b};
        return d[DW-1] ? (~d + 1'b1) : d;
    endfunction

    // sign of a coordinate difference
    function automatic logic dneg(logic signed [CB-1:0] a, logic signed [CB-1:0] b);
        logic [DW-1:0] d;
        d = {a[CB-1], a} - {b[CB-1], b};
        return d[DW-1];
    endfunction

    logic [4*CB-1:0]        ram_rdata;
    logic signed [CB-1:0]   sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [CB-1:0]   px_reg, py_reg, cx_reg, cy_reg;
    logic signed [CB-1:0]   qx, qy;
    logic [SQW-1:0]         sq1_reg, sq2_reg, sq3_reg, sq4_reg;
    logic [SQW-1:0]         m1_reg, m2_reg;
    logic [CW-1:0]          c_reg, bc_reg;
    logic [LW-1:0]          bl_reg, bd_reg;
    logic [PW-1:0]          pc1_reg, pc2_reg;
    mop_t                   mop_reg;
    logic [LW-1:0]          l_val, de_val, d_val, x_val, m1e, m2e;
    logic                   s1, s2;
    logic [DW-1:0]          fa, fb;
    logic [CW-1:0]          ma;
    logic [LW-1:0]          mb;
    logic                   mul_done;
    logic [PW-1:0]          mul_p;
    logic signed [CB-1:0]   os_x_reg, os_y_reg, oe_x_reg, oe_y_reg;
    logic [SRC_IDX_W-1:0]   oidx_reg;
    logic                   orev_reg, olast_reg;

    // segment store
    wsco_ram #(
        .WIDTH (4 * CB),
        .DEPTH (MAX_SEGMENTS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_idx),
        .wdata ({seg_start_x[CB-1:0], seg_start_y[CB-1:0],
                 seg_end_x[CB-1:0], seg_end_y[CB-1:0]}),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // shared multiplier
    wsco_mul #(
        .AW (CW),
        .BW (LW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.mul_go),
        .a     (ma),
        .b     (mb),
        .done  (mul_done),
        .p     (mul_p)
    );

    // reference point: pose while orienting, chain end while chaining
    assign qx = cmd.chain_mode ? cx_reg : px_reg;
    assign qy = cmd.chain_mode ? cy_reg : py_reg;

    // squared lengths and distances
    assign l_val  = LW'(sq1_reg) + LW'(sq2_reg);
    assign de_val = LW'(sq3_reg) + LW'(sq4_reg);

    // magnitude of the cross product from its two partial products
    assign s1  = dneg(px_reg, sx_reg) ^ dneg(ey_reg, sy_reg);
    assign s2  = dneg(py_reg, sy_reg) ^ dneg(ex_reg, sx_reg);
    assign m1e = LW'(m1_reg);
    assign m2e = LW'(m2_reg);
    always_comb
    begin
        if (s1 != s2)
        begin
            x_val = m1e + m2e;
        end
        else if (m1e >= m2e)
        begin
            x_val = m1e - m2e;
        end
        else
        begin
            x_val = m2e - m1e;
        end
    end

    // nearer endpoint distance
    assign d_val = stat.end_nearer ? de_val : l_val;

    // multiplier operand selection
    always_comb
    begin
        fa = '0;
        fb = '0;
        case (cmd.mop)
            MOP_L_DX:
            begin
                fa = absd(sx_reg, ex_reg);
                fb = fa;
            end
            MOP_L_DY:
            begin
                fa = absd(sy_reg, ey_reg);
                fb = fa;
            end
            MOP_AXBY:
            begin
                fa = absd(px_reg, sx_reg);
                fb = absd(ey_reg, sy_reg);
            end
            MOP_AYBX:
            begin
                fa = absd(py_reg, sy_reg);
                fb = absd(ex_reg, sx_reg);
            end
            MOP_QS_DX:
            begin
                fa = absd(qx, sx_reg);
                fb = fa;
            end
            MOP_QS_DY:
            begin
                fa = absd(qy, sy_reg);
                fb = fa;
            end
            MOP_QE_DX:
            begin
                fa = absd(qx, ex_reg);
                fb = fa;
            end
            MOP_QE_DY:
            begin
                fa = absd(qy, ey_reg);
                fb = fa;
            end
            default:
            begin
                fa = '0;
                fb = '0;
            end
        endcase
        case (cmd.mop)
            MOP_XX:
            begin
                ma = CW'(x_val);
                mb = x_val;
            end
            MOP_CBL:
            begin
                ma = c_reg;
                mb = bl_reg;
            end
            MOP_BCL:
            begin
                ma = bc_reg;
                mb = l_val;
            end
            default:
            begin
                ma = CW'(fa);
                mb = LW'(fb);
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.pose_ld)
        begin
            px_reg <= pose_x[CB-1:0];
            py_reg <= pose_y[CB-1:0];
        end
        if (cmd.seg_ld)
        begin
            sx_reg <= ram_rdata[4*CB-1:3*CB];
            sy_reg <= ram_rdata[3*CB-1:2*CB];
            ex_reg <= ram_rdata[2*CB-1:CB];
            ey_reg <= ram_rdata[CB-1:0];
        end
        if (cmd.mul_go)
        begin
            mop_reg <= cmd.mop;
        end
        if (mul_done)
        begin
            case (mop_reg)
                MOP_L_DX, MOP_QS_DX: sq1_reg <= mul_p[SQW-1:0];
                MOP_L_DY, MOP_QS_DY: sq2_reg <= mul_p[SQW-1:0];
                MOP_QE_DX:           sq3_reg <= mul_p[SQW-1:0];
                MOP_QE_DY:           sq4_reg <= mul_p[SQW-1:0];
                MOP_AXBY:            m1_reg  <= mul_p[SQW-1:0];
                MOP_AYBX:            m2_reg  <= mul_p[SQW-1:0];
                MOP_XX:              c_reg   <= mul_p[CW-1:0];
                MOP_CBL:             pc1_reg <= mul_p;
                MOP_BCL:             pc2_reg <= mul_p;
                default:             pc2_reg <= pc2_reg;
            endcase
        end
        if (cmd.best_ld)
        begin
            if (cmd.chain_mode)
            begin
                bd_reg <= d_val;
            end
            else
            begin
                bc_reg <= c_reg;
                bl_reg <= l_val;
            end
        end
        if (cmd.emit_ld)
        begin
            os_x_reg  <= cmd.emit_rev ? ex_reg : sx_reg;
            os_y_reg  <= cmd.emit_rev ? ey_reg : sy_reg;
            oe_x_reg  <= cmd.emit_rev ? sx_reg : ex_reg;
            oe_y_reg  <= cmd.emit_rev ? sy_reg : ey_reg;
            cx_reg    <= cmd.emit_rev ? sx_reg : ex_reg;
            cy_reg    <= cmd.emit_rev ? sy_reg : ey_reg;
            oidx_reg  <= SRC_IDX_W'(rd_idx);
            orev_reg  <= cmd.emit_rev;
            olast_reg <= cmd.emit_last;
        end
    end

    // status to controller
    assign stat.mul_done   = mul_done;
    assign stat.l_zero     = (l_val == '0);
    assign stat.prod_less  = (pc1_reg < pc2_reg);
    assign stat.end_nearer = (de_val < l_val);
    assign stat.dist_less  = (d_val < bd_reg);

    // result word
    assign out_start_x  = FIELD_W'(os_x_reg);
    assign out_start_y  = FIELD_W'(os_y_reg);
    assign out_end_x    = FIELD_W'(oe_x_reg);
    assign out_end_y    = FIELD_W'(oe_y_reg);
    assign source_index = oidx_reg;
    assign was_reversed = orev_reg;
    assign last_out     = olast_reg;

endmodule

### sv/wsco_ctrl.sv
// ----------------------------------------------------------------------------
// wsco_ctrl
// controller: load counting, line search, orientation and greedy chaining
// ----------------------------------------------------------------------------
`include "wall_segment_chain_order_macros.svh"

module wsco_ctrl import wsco_pkg::*; #(
    parameter int MAX_SEGMENTS = WSCO_MAX_SEGMENTS,
    localparam int IW          = $clog2(MAX_SEGMENTS),
    localparam int CNTW        = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          in_last,
    output logic          out_valid,
    input  logic          out_ready,
    output cmd_t          cmd,
    input  stat_t         stat,
    output logic [IW-1:0] wr_idx,
    output logic [IW-1:0] rd_idx
);

    state_t                  state_reg, state_next;
    phase_t                  ph_reg, ph_next;
    logic [2:0]              stp_reg, stp_next;
    logic [CNTW-1:0]         cnt_reg, cnt_next;
    logic [CNTW-1:0]         n_reg, n_next;
    logic [CNTW-1:0]         i_reg, i_next;
    logic [CNTW-1:0]         k_reg, k_next;
    logic [IW-1:0]           best_reg, best_next;
    logic                    have_reg, have_next;
    logic                    rev_reg, rev_next;
    logic [MAX_SEGMENTS-1:0] used_reg, used_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    room;
    logic [CNTW-1:0]         cnt_inc;
    logic                    emit_last;

    assign room      = (cnt_reg < CNTW'(MAX_SEGMENTS));
    assign cnt_inc   = room ? (cnt_reg + 1'b1) : cnt_reg;
    assign emit_last = ((k_reg + 1'b1) == n_reg);
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign wr_idx    = cnt_reg[IW-1:0];

    // read the scanned entry, otherwise the chosen one
    assign rd_idx = (state_reg == ST_READ && (ph_reg == PH_LINE || ph_reg == PH_CHAIN))
                    ? i_reg[IW-1:0] : best_reg;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        stp_next       = stp_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        best_next      = best_reg;
        have_next      = have_reg;
        rev_next       = rev_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.chain_mode = (ph_reg == PH_CHAIN);
        cmd.emit_rev   = rev_reg;
        cmd.emit_last  = emit_last;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // multiply op for the current step
        if (ph_reg == PH_LINE)
        begin
            case (stp_reg)
                3'd0:    cmd.mop = MOP_L_DX;
                3'd1:    cmd.mop = MOP_L_DY;
                3'd2:    cmd.mop = MOP_AXBY;
                3'd3:    cmd.mop = MOP_AYBX;
                3'd4:    cmd.mop = MOP_XX;
                3'd5:    cmd.mop = MOP_CBL;
                default: cmd.mop = MOP_BCL;
            endcase
        end
        else
        begin
            case (stp_reg)
                3'd0:    cmd.mop = MOP_QS_DX;
                3'd1:    cmd.mop = MOP_QS_DY;
                3'd2:    cmd.mop = MOP_QE_DX;
                default: cmd.mop = MOP_QE_DY;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.wr_en = room;
                    cnt_next  = cnt_inc;
                    if (in_last)
                    begin
                        cmd.pose_ld = 1'b1;
                        cnt_next    = '0;
                        n_next      = cnt_inc;
                        i_next      = '0;
                        k_next      = '0;
                        best_next   = '0;
                        have_next   = 1'b0;
                        used_next   = '0;
                        ph_next     = PH_LINE;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (i_reg == n_reg)
                begin
                    ph_next    = (ph_reg == PH_LINE) ? PH_ORIENT : PH_OUT;
                    state_next = ST_READ;
                end
                else if (used_reg[i_reg[IW-1:0]])
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                cmd.seg_ld = 1'b1;
                stp_next   = '0;
                state_next = (ph_reg == PH_OUT) ? ST_EMIT : ST_MGO;
            end
            ST_MGO:
            begin
                cmd.mul_go = 1'b1;
                state_next = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                if (stat.mul_done)
                begin
                    stp_next   = stp_reg + 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (ph_reg == PH_LINE)
                begin
                    if (stp_reg == 3'd2 && stat.l_zero)
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                    else if ((stp_reg == 3'd5 && !have_reg) || stp_reg == 3'd7)
                    begin
                        state_next = ST_EVAL;
                    end
                    else
                    begin
                        state_next = ST_MGO;
                    end
                end
                else
                begin
                    state_next = (stp_reg == 3'd4) ? ST_EVAL : ST_MGO;
                end
            end
            ST_EVAL:
            begin
                case (ph_reg)
                    PH_LINE:
                    begin
                        if (!have_reg || stat.prod_less)
                        begin
                            have_next   = 1'b1;
                            best_next   = i_reg[IW-1:0];
                            cmd.best_ld = 1'b1;
                        end
                        i_next     = i_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                    PH_ORIENT:
                    begin
                        rev_next   = stat.end_nearer;
                        state_next = ST_EMIT;
                    end
                    default:
                    begin
                        if (!have_reg || stat.dist_less)
                        begin
                            have_next   = 1'b1;
                            best_next   = i_reg[IW-1:0];
                            rev_next    = stat.end_nearer;
                            cmd.best_ld = 1'b1;
                        end
                        i_next     = i_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                endcase
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit_ld         = 1'b1;
                    out_valid_next      = 1'b1;
                    used_next[best_reg] = 1'b1;
                    k_next              = k_reg + 1'b1;
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ph_next    = PH_CHAIN;
                        i_next     = '0;
                        have_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ph_reg        <= PH_LINE;
            stp_reg       <= '0;
            cnt_reg       <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            best_reg      <= '0;
            have_reg      <= 1'b0;
            rev_reg       <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            stp_reg       <= stp_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            best_reg      <= best_next;
            have_reg      <= have_next;
            rev_reg       <= rev_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // checks
    `WSCO_NEVER(a_emit_unused, cmd.emit_ld && used_reg[best_reg], "segment emitted twice")
    `WSCO_NEVER(a_emit_overwrite, cmd.emit_ld && out_valid_reg && !out_ready, "result word overwritten")
    `WSCO_ASSERT(a_done_in_wait, stat.mul_done |-> (state_reg == ST_MWAIT), "multiply done out of place")
    `WSCO_ASSERT(a_all_used, (cmd.emit_ld && emit_last) |=> ($countones(used_reg) == n_reg), "run ended with segments left")

endmodule

### sv/wall_segment_chain_order.sv
// ----------------------------------------------------------------------------
// wall_segment_chain_order
// orders a set of wall segments into a greedy nearest-neighbor chain
// ----------------------------------------------------------------------------
// Segments load one word per cycle. The word flagged last_segment also carries
// the pose and starts ordering: the block takes no input until every segment of
// the set has been emitted. All products go through one shift-add multiplier.
// The nearest-line search costs up to seven products per segment, the start
// orientation four, and each chaining step four per unused segment, so a set
// of n segments takes roughly (7n + 2n(n-1) + 4) products. A finished word
// waits in an output register and does not stop the search for the next one.
module wall_segment_chain_order import wsco_pkg::*; #(
    parameter int MAX_SEGMENTS = WSCO_MAX_SEGMENTS,
    parameter int COORD_BITS   = WSCO_COORD_BITS,
    localparam int IW          = $clog2(MAX_SEGMENTS)
) (
    input logic        clk,
    input logic        rst_n,
    wsco_in_if.sink    segs,
    wsco_out_if.source ordered
);

    cmd_t          cmd;
    stat_t         stat;
    logic [IW-1:0] wr_idx;
    logic [IW-1:0] rd_idx;

    // controller
    wsco_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (segs.valid),
        .in_ready  (segs.ready),
        .in_last   (segs.last_segment),
        .out_valid (ordered.valid),
        .out_ready (ordered.ready),
        .cmd       (cmd),
        .stat      (stat),
        .wr_idx    (wr_idx),
        .rd_idx    (rd_idx)
    );

    // datapath
    wsco_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .wr_idx       (wr_idx),
        .rd_idx       (rd_idx),
        .seg_start_x  (segs.seg_start_x),
        .seg_start_y  (segs.seg_start_y),
        .seg_end_x    (segs.seg_end_x),
        .seg_end_y    (segs.seg_end_y),
        .pose_x       (segs.pose_x),
        .pose_y       (segs.pose_y),
        .out_start_x  (ordered.out_start_x),
        .out_start_y  (ordered.out_start_y),
        .out_end_x    (ordered.out_end_x),
        .out_end_y    (ordered.out_end_y),
        .source_index (ordered.source_index),
        .was_reversed (ordered.was_reversed),
        .last_out     (ordered.last_out)
    );

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for wall_segment_chain_order
// loads sets of wall segments with a pose on the last word and checks every
// ordered word against a predictor that redoes the nearest-line search and the
// greedy chaining with exact wide arithmetic
// ----------------------------------------------------------------------------
module testbench;
    import wsco_pkg::*;

    typedef struct {
        logic signed [31:0] sx, sy, ex, ey;
        logic [4:0]         idx;
        logic               rev, last;
    } ordered_word_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   words_sent;
    bit   calm;

    ordered_word_t chain_q[$];

    // predictor state
    logic signed [31:0] wall_sx[WSCO_MAX_SEGMENTS];
    logic signed [31:0] wall_sy[WSCO_MAX_SEGMENTS];
    logic signed [31:0] wall_ex[WSCO_MAX_SEGMENTS];
    logic signed [31:0] wall_ey[WSCO_MAX_SEGMENTS];
    int                 wall_count;

    wsco_in_if  segs();
    wsco_out_if ordered();

    wall_segment_chain_order u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .segs    (segs),
        .ordered (ordered)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // squared distance between two points
    function automatic logic [255:0] sq_dist(logic signed [31:0] ax, logic signed [31:0] ay,
                                            logic signed [31:0] bx, logic signed [31:0] by);
        logic signed [255:0] dx;
        logic signed [255:0] dy;
        dx = ax;
        dx = dx - bx;
        dy = ay;
        dy = dy - by;
        return dx * dx + dy * dy;
    endfunction

    // squared cross product of (pose - start) and (end - start)
    function automatic logic [255:0] sq_cross(logic signed [31:0] px, logic signed [31:0] py,
                                             int i);
        logic signed [255:0] ax, ay, bx, by, c;
        ax = px;         ax = ax - wall_sx[i];
        ay = py;         ay = ay - wall_sy[i];
        bx = wall_ex[i]; bx = bx - wall_sx[i];
        by = wall_ey[i]; by = by - wall_sy[i];
        c = ax * by - ay * bx;
        return c * c;
    endfunction

    task automatic push_word(int i, bit rev, bit last,
                             ref logic signed [31:0] cx, ref logic signed [31:0] cy);
        ordered_word_t w;
        w.sx   = rev ? wall_ex[i] : wall_sx[i];
        w.sy   = rev ? wall_ey[i] : wall_sy[i];
        w.ex   = rev ? wall_sx[i] : wall_ex[i];
        w.ey   = rev ? wall_sy[i] : wall_ey[i];
        w.idx  = i[4:0];
        w.rev  = rev;
        w.last = last;
        cx = w.ex;
        cy = w.ey;
        chain_q.insert(chain_q.size(), w);
    endtask

    // store one word; on the last word order the whole set
    task automatic order_walls(logic signed [31:0] sx, logic signed [31:0] sy,
                               logic signed [31:0] ex, logic signed [31:0] ey,
                               bit last, logic signed [31:0] px, logic signed [31:0] py);
        bit                 used[WSCO_MAX_SEGMENTS];
        bit                 have, found, rev, r;
        int                 first, bi, n;
        logic [255:0]       bc, bl, c, l, ds, de, d, bd;
        logic signed [31:0] cx, cy;
        if (wall_count < WSCO_MAX_SEGMENTS)
        begin
            wall_sx[wall_count] = sx;
            wall_sy[wall_count] = sy;
            wall_ex[wall_count] = ex;
            wall_ey[wall_count] = ey;
            wall_count++;
        end
        if (!last)
            return;
        n = wall_count;
        foreach (used[i])
            used[i] = 0;
        // nearest infinite line, zero-length walls skipped, earliest wins ties
        have  = 0;
        first = 0;
        bc    = '0;
        bl    = '0;
        for (int i = 0; i < n; i++)
        begin
            l = sq_dist(wall_sx[i], wall_sy[i], wall_ex[i], wall_ey[i]);
            if (l == 0)
                continue;
            c = sq_cross(px, py, i);
            if (!have || c * bl < bc * l)
            begin
                have = 1; first = i; bc = c; bl = l;
            end
        end
        rev = sq_dist(px, py, wall_sx[first], wall_sy[first])
              > sq_dist(px, py, wall_ex[first], wall_ey[first]);
        push_word(first, rev, n == 1, cx, cy);
        used[first] = 1;
        // greedy chaining from the current end point
        for (int k = 1; k < n; k++)
        begin
            found = 0; bi = 0; rev = 0; bd = '0;
            for (int i = 0; i < n; i++)
            begin
                if (used[i])
                    continue;
                ds = sq_dist(cx, cy, wall_sx[i], wall_sy[i]);
                de = sq_dist(cx, cy, wall_ex[i], wall_ey[i]);
                r  = de < ds;
                d  = r ? de : ds;
                if (!found || d < bd)
                begin
                    found = 1; bi = i; rev = r; bd = d;
                end
            end
            push_word(bi, rev, k + 1 == n, cx, cy);
            used[bi] = 1;
        end
        wall_count = 0;
    endtask

    // send one segment word, with random idle cycles ahead of it
    task automatic send_wall(logic signed [31:0] sx, logic signed [31:0] sy,
                             logic signed [31:0] ex, logic signed [31:0] ey,
                             bit last, logic signed [31:0] px, logic signed [31:0] py);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(99) < 9)
            begin
                segs.valid = 1'b0;
                continue;
            end
            segs.valid        = 1'b1;
            segs.seg_start_x  = sx;
            segs.seg_start_y  = sy;
            segs.seg_end_x    = ex;
            segs.seg_end_y    = ey;
            segs.last_segment = last;
            segs.pose_x       = px;
            segs.pose_y       = py;
            break;
        end
        @(posedge clk);
        while (!segs.ready)
            @(posedge clk);
        order_walls(sx, sy, ex, ey, last, px, py);
        words_sent++;
    endtask

    // drop valid and wait for every ordered word of the set
    task automatic drain();
        @(negedge clk);
        segs.valid = 1'b0;
        while (chain_q.size() != 0)
            @(posedge clk);
    endtask

    // output stall
    always @(negedge clk)
        ordered.ready = calm ? 1'b1 : ($urandom_range(99) >= 9);

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // compare each ordered word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && ordered.valid && ordered.ready)
        begin
            if (chain_q.size() == 0)
            begin
                $error("unexpected ordered word, source_index %0d", ordered.source_index);
                errors++;
            end
            else
            begin
                ordered_word_t w;
                w = chain_q.pop_front();
                check_field("out_start_x", w.sx, ordered.out_start_x);
                check_field("out_start_y", w.sy, ordered.out_start_y);
                check_field("out_end_x", w.ex, ordered.out_end_x);
                check_field("out_end_y", w.ey, ordered.out_end_y);
                check_field("source_index", w.idx, ordered.source_index);
                check_field("was_reversed", w.rev, ordered.was_reversed);
                check_field("last_out", w.last, ordered.last_out);
            end
        end
    end

    // one-wall and two-wall sets at the coordinate extremes
    task automatic test_extremes();
        send_wall(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1,
                  32'sh7fffffff, 32'sh7fffffff);
        drain();
        send_wall(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0);
        send_wall(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1,
                  32'sh80000000, 32'sh7fffffff);
        drain();
    endtask

    // zero-length walls are skipped by the line search; a set of only zero-length walls starts at wall 0
    task automatic test_zero_length();
        send_wall(5, 5, 5, 5, 0, 0, 0);
        send_wall(-3, 2, -3, 2, 0, 0, 0);
        send_wall(7, 7, 7, 7, 1, 1, 1);
        drain();
        send_wall(0, 0, 0, 0, 0, 0, 0);
        send_wall(100, 0, 200, 0, 1, 0, 0);
        drain();
    endtask

    // equal line distances go to the earliest wall
    task automatic test_line_tie();
        send_wall(-4, 1, 4, 1, 0, 0, 0);
        send_wall(4, -1, -4, -1, 1, 0, 0);
        drain();
        send_wall(0, 0, 0, 0, 0, 0, 0);
        send_wall(8, -2, -8, -2, 0, 0, 0);
        send_wall(-8, 2, 8, 2, 1, 0, 0);
        drain();
    endtask

    // equally near endpoints keep the wall forward, earliest candidate wins
    task automatic test_endpoint_tie();
        send_wall(-1, 0, 1, 0, 0, 0, 0);
        send_wall(3, 2, 3, -2, 0, 0, 0);
        send_wall(-1, 2, -1, -2, 0, 0, 0);
        send_wall(1, 4, 1, 8, 1, 0, 5);
        drain();
    endtask

    // a full store drops the extra word but still orders on its last mark
    task automatic test_store_full();
        for (int i = 0; i < WSCO_MAX_SEGMENTS; i++)
            send_wall(i * 16, i[0] ? 3 : 0, i * 16 + 10, i[1] ? -5 : 5, 0, $urandom, $urandom);
        send_wall(32'sh40000000, 0, 32'sh40000100, 0, 1, 7, 3);
        drain();
    endtask

    // random sets, mostly connected walls, some noise and tiny values
    task automatic test_random_sets();
        int                 n, mode, sets;
        logic signed [31:0] sx, sy, ex, ey, px, py, jx, jy;
        sets = 0;
        while (words_sent < 170)
        begin
            calm = (sets >= 12 && sets < 18);
            n = ($urandom_range(9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
            mode = $urandom_range(9);
            jx = $urandom_range(65535) - 32768;
            jy = $urandom_range(65535) - 32768;
            for (int i = 0; i < n; i++)
            begin
                if (mode < 6)
                begin
                    sx = jx; sy = jy;
                    ex = jx + $urandom_range(131071) - 65536;
                    ey = jy + $urandom_range(131071) - 65536;
                    jx = ex; jy = ey;
                    if ($urandom_range(1))
                    begin
                        sx = ex; sy = ey; ex = jx - (ex - sx); ey = sy;
                        ex = $urandom_range(131071) - 65536;
                    end
                end
                else if (mode < 8)
                begin
                    sx = $urandom; sy = $urandom; ex = $urandom; ey = $urandom;
                end
                else
                begin
                    sx = $urandom_range(3); sy = $urandom_range(3);
                    ex = $urandom_range(3); ey = $urandom_range(3);
                end
                px = (mode >= 6 && mode < 8) ? $urandom : $urandom_range(262143) - 131072;
                py = (mode >= 6 && mode < 8) ? $urandom : $urandom_range(262143) - 131072;
                send_wall(sx, sy, ex, ey, i == n - 1, px, py);
            end
            drain();
            sets++;
        end
        calm = 0;
    endtask

    // run limit
    initial
    begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        errors            = 0;
        words_sent        = 0;
        wall_count        = 0;
        calm              = 0;
        rst_n             = 1'b0;
        segs.valid        = 1'b0;
        segs.seg_start_x  = '0;
        segs.seg_start_y  = '0;
        segs.seg_end_x    = '0;
        segs.seg_end_y    = '0;
        segs.last_segment = 1'b0;
        segs.pose_x       = '0;
        segs.pose_y       = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_zero_length();
        test_line_tie();
        test_endpoint_tie();
        test_store_full();
        test_random_sets();

        repeat (200) @(posedge clk);
        if (errors == 0 && chain_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
